### sv/nnsa_pkg.sv
// nnsa_pkg: shared types and constants of the nearest neighbor scale addresser
// register map, reset values, config bundle, queue status and back-end state type; no dependencies
package nnsa_pkg;

  localparam int SRC_DIM_W = 13;
  localparam int SCR_DIM_W = 12;
  localparam int PITCH_W   = 14;
  localparam int IDX_W     = 24;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic [SRC_DIM_W-1:0] SRC_W_RST = 13'd320;
  localparam logic [SRC_DIM_W-1:0] SRC_H_RST = 13'd200;
  localparam logic [SCR_DIM_W-1:0] SCR_W_RST = 12'd640;
  localparam logic [SCR_DIM_W-1:0] SCR_H_RST = 12'd480;
  localparam logic [PITCH_W-1:0]   PITCH_RST = 14'd640;

  typedef enum logic [2:0] {
    REG_SRC_W = 3'd0,
    REG_SRC_H = 3'd1,
    REG_SCR_W = 3'd2,
    REG_SCR_H = 3'd3,
    REG_PITCH = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [SRC_DIM_W-1:0] src_w;
    logic [SRC_DIM_W-1:0] src_h;
    logic [PITCH_W-1:0]   pitch;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_DIV_X,
    ST_MUL_Y,
    ST_DIV_Y,
    ST_MUL_SRC,
    ST_MUL_DST,
    ST_OUT
  } back_st_t;

endpackage

### sv/nnsa_front.sv
// nnsa_front: raster walker, takes requests and classifies restart / out of screen
// depends on nnsa_pkg for the queue status type
module nnsa_front #(
  parameter int CW = 11
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic             in_restart,
  output logic             full,
  input  logic [CW-1:0]    w_eff,
  input  logic [CW-1:0]    h_eff,
  input  nnsa_pkg::q_stat_t q_stat,
  output logic             q_push,
  output logic [2*CW:0]    q_wdata
);

  localparam logic [CW:0] ONE_E = 1;
  localparam logic [CW-1:0] ONE = 1;

  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic          restart_pos;
  logic [CW-1:0] x, y;
  logic          last;
  logic          x_wrap, y_wrap;

  always_comb begin
    // restart request or a screen shrunk under the current position
    restart_pos = in_restart || (col_r >= w_eff) || (row_r >= h_eff);
    x = restart_pos ? '0 : col_r;
    y = restart_pos ? '0 : row_r;
    last = (x == w_eff - ONE) && (y == h_eff - ONE);
    x_wrap = ({1'b0, x} + ONE_E) >= {1'b0, w_eff};
    y_wrap = ({1'b0, y} + ONE_E) >= {1'b0, h_eff};
    if (x_wrap) begin
      col_nxt = '0;
      row_nxt = y_wrap ? '0 : y + ONE;
    end else begin
      col_nxt = x + ONE;
      row_nxt = y;
    end
  end

  assign full    = q_stat.full;
  assign q_push  = push && !q_stat.full;
  assign q_wdata = {x, y, last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (q_push) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

### sv/nnsa_queue.sv
// nnsa_queue: two-entry queue of pixel positions between front and back
// depends on nnsa_pkg for the status type
module nnsa_queue #(
  parameter int DW = 23
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_push,
  input  logic [DW-1:0]     q_wdata,
  input  logic              q_pop,
  output logic [DW-1:0]     q_rdata,
  output nnsa_pkg::q_stat_t q_stat
);

  logic [DW-1:0] mem_r [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign q_rdata      = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push && !q_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (q_pop && !q_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (q_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      mem_r[wr_ptr_r] <= q_wdata;
    end
  end

endmodule

### sv/nnsa_back.sv
// nnsa_back: index engine, bit-serial divider and multipliers, result register
// depends on nnsa_pkg for the config bundle, queue status and state type
module nnsa_back #(
  parameter int CW = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  nnsa_pkg::q_stat_t          q_stat,
  input  logic [2*CW:0]              q_rdata,
  output logic                       q_pop,
  input  logic [CW-1:0]              w_eff,
  input  logic [CW-1:0]              h_eff,
  input  nnsa_pkg::cfg_t             cfg,
  output logic                       empty,
  input  logic                       pop,
  output logic [nnsa_pkg::IDX_W-1:0] out_source_index,
  output logic [nnsa_pkg::IDX_W-1:0] out_dest_index,
  output logic                       out_frame_last
);

  localparam int SW   = nnsa_pkg::SRC_DIM_W;
  localparam int IW   = nnsa_pkg::IDX_W;
  localparam int NW   = CW + SW;
  localparam int CNTW = $clog2(NW);
  localparam int PW   = CW + nnsa_pkg::PITCH_W;
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(NW - 1);

  nnsa_pkg::back_st_t st_r, st_nxt;

  logic [CW-1:0]   x_r, y_r;
  logic            last_r;
  logic [SW-1:0]   sx_r;
  logic [IW-1:0]   src_r, dst_r;
  logic [NW-1:0]   num_r;
  logic [CW-1:0]   rem_r;
  logic [CNTW-1:0] cnt_r;
  logic            out_valid_r;
  logic [IW-1:0]   out_src_r, out_dst_r;
  logic            out_last_r;

  logic            slot_free;
  logic            div_run, div_done, out_load;
  logic [CW-1:0]   dsr;
  logic [CW:0]     trial, trial_sub;
  logic            ge;
  logic [NW-1:0]   mul_x, mul_y;
  logic [2*SW-1:0] src_prod;
  logic [PW-1:0]   dst_prod;

  assign slot_free = !out_valid_r || pop;

  // one quotient bit a step, remainder stays below the divisor
  assign dsr       = (st_r == nnsa_pkg::ST_DIV_X) ? w_eff : h_eff;
  assign trial     = {rem_r, num_r[NW-1]};
  assign trial_sub = trial - {1'b0, dsr};
  assign ge        = trial >= {1'b0, dsr};
  assign div_done  = (cnt_r == CNT_LAST);

  assign mul_x    = NW'(x_r) * NW'(cfg.src_w);
  assign mul_y    = NW'(y_r) * NW'(cfg.src_h);
  assign src_prod = {{SW{1'b0}}, num_r[SW-1:0]} * {{SW{1'b0}}, cfg.src_w};
  assign dst_prod = PW'(y_r) * PW'(cfg.pitch);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      nnsa_pkg::ST_IDLE:    if (!q_stat.empty) st_nxt = nnsa_pkg::ST_MUL_X;
      nnsa_pkg::ST_MUL_X:   st_nxt = nnsa_pkg::ST_DIV_X;
      nnsa_pkg::ST_DIV_X:   if (div_done) st_nxt = nnsa_pkg::ST_MUL_Y;
      nnsa_pkg::ST_MUL_Y:   st_nxt = nnsa_pkg::ST_DIV_Y;
      nnsa_pkg::ST_DIV_Y:   if (div_done) st_nxt = nnsa_pkg::ST_MUL_SRC;
      nnsa_pkg::ST_MUL_SRC: st_nxt = nnsa_pkg::ST_MUL_DST;
      nnsa_pkg::ST_MUL_DST: st_nxt = nnsa_pkg::ST_OUT;
      nnsa_pkg::ST_OUT:     if (slot_free) st_nxt = nnsa_pkg::ST_IDLE;
      default:              st_nxt = nnsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    div_run  = 1'b0;
    out_load = 1'b0;
    unique case (st_r)
      nnsa_pkg::ST_IDLE:  q_pop    = !q_stat.empty;
      nnsa_pkg::ST_DIV_X,
      nnsa_pkg::ST_DIV_Y: div_run  = 1'b1;
      nnsa_pkg::ST_OUT:   out_load = slot_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= nnsa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      {x_r, y_r, last_r} <= q_rdata;
    end
    if (st_r == nnsa_pkg::ST_MUL_X) begin
      num_r <= mul_x;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (st_r == nnsa_pkg::ST_MUL_Y) begin
      sx_r  <= num_r[SW-1:0];
      num_r <= mul_y;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (div_run) begin
      num_r <= {num_r[NW-2:0], ge};
      rem_r <= ge ? trial_sub[CW-1:0] : trial[CW-1:0];
      cnt_r <= cnt_r + CNTW'(1);
    end
    if (st_r == nnsa_pkg::ST_MUL_SRC) begin
      src_r <= src_prod[IW-1:0];
    end
    if (st_r == nnsa_pkg::ST_MUL_DST) begin
      dst_r <= IW'(dst_prod);
    end
    if (out_load) begin
      out_src_r  <= src_r + IW'(sx_r);
      out_dst_r  <= dst_r + IW'(x_r);
      out_last_r <= last_r;
    end
  end

  assign empty            = !out_valid_r;
  assign out_source_index = out_src_r;
  assign out_dest_index   = out_dst_r;
  assign out_frame_last   = out_last_r;

endmodule

### sv/nearest_neighbor_scale_addresser_top.sv
// nearest_neighbor_scale_addresser_top: config registers, front, queue and back
// depends on nnsa_pkg, nnsa_front, nnsa_queue and nnsa_back
//
//   channel  | ports                                          | accepted when
//   request  | push, full, in_restart                         | push && !full
//   result   | empty, pop, out_source_index, out_dest_index,  | pop && !empty
//            | out_frame_last                                 |
//   config   | psel, penable, pwrite, paddr, pwdata, prdata,  | psel && penable &&
//            | pready                                         | pwrite && pready
//
// the back end works on one request at a time, through a bit-serial divider
// that runs once for the column and once for the row; the raster counters
// advance as the request is taken
// a two-entry queue lets the front take requests while the back end works
// and the result register holds a finished result until it is popped
// rst_n is synchronous; reset restores register defaults and position 0,0
module nearest_neighbor_scale_addresser_top #(
  parameter int MAX_SCREEN_W = 1920,
  parameter int MAX_SCREEN_H = 1200
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_restart,
  output logic                        empty,
  input  logic                        pop,
  output logic [nnsa_pkg::IDX_W-1:0]  out_source_index,
  output logic [nnsa_pkg::IDX_W-1:0]  out_dest_index,
  output logic                        out_frame_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nnsa_pkg::ADDR_W-1:0] paddr,
  input  logic [nnsa_pkg::DATA_W-1:0] pwdata,
  output logic [nnsa_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int XW = $clog2(MAX_SCREEN_W + 1);
  localparam int YW = $clog2(MAX_SCREEN_H + 1);
  localparam int CW = (XW > YW) ? XW : YW;
  localparam int SCW = nnsa_pkg::SCR_DIM_W;
  localparam logic [SCW-1:0] MAX_W = SCW'(MAX_SCREEN_W);
  localparam logic [SCW-1:0] MAX_H = SCW'(MAX_SCREEN_H);

  logic [nnsa_pkg::SRC_DIM_W-1:0] src_w_r, src_h_r;
  logic [SCW-1:0]                 scr_w_r, scr_h_r;
  logic [nnsa_pkg::PITCH_W-1:0]   pitch_r;
  logic                           wr_en;
  nnsa_pkg::reg_idx_t             reg_idx;
  nnsa_pkg::cfg_t                 cfg;
  logic [CW-1:0]                  w_eff, h_eff;

  nnsa_pkg::q_stat_t q_stat;
  logic              q_push, q_pop;
  logic [2*CW:0]     q_wdata, q_rdata;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = nnsa_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= nnsa_pkg::SRC_W_RST;
      src_h_r <= nnsa_pkg::SRC_H_RST;
      scr_w_r <= nnsa_pkg::SCR_W_RST;
      scr_h_r <= nnsa_pkg::SCR_H_RST;
      pitch_r <= nnsa_pkg::PITCH_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        nnsa_pkg::REG_SRC_W: src_w_r <= pwdata[nnsa_pkg::SRC_DIM_W-1:0];
        nnsa_pkg::REG_SRC_H: src_h_r <= pwdata[nnsa_pkg::SRC_DIM_W-1:0];
        nnsa_pkg::REG_SCR_W: scr_w_r <= pwdata[SCW-1:0];
        nnsa_pkg::REG_SCR_H: scr_h_r <= pwdata[SCW-1:0];
        nnsa_pkg::REG_PITCH: pitch_r <= pwdata[nnsa_pkg::PITCH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      nnsa_pkg::REG_SRC_W: prdata = nnsa_pkg::DATA_W'(src_w_r);
      nnsa_pkg::REG_SRC_H: prdata = nnsa_pkg::DATA_W'(src_h_r);
      nnsa_pkg::REG_SCR_W: prdata = nnsa_pkg::DATA_W'(scr_w_r);
      nnsa_pkg::REG_SCR_H: prdata = nnsa_pkg::DATA_W'(scr_h_r);
      nnsa_pkg::REG_PITCH: prdata = nnsa_pkg::DATA_W'(pitch_r);
      default:             prdata = '0;
    endcase
  end

  // clamp to the maximum screen, zero acts as one
  always_comb begin
    if (scr_w_r > MAX_W) begin
      w_eff = CW'(MAX_SCREEN_W);
    end else if (scr_w_r == '0) begin
      w_eff = CW'(1);
    end else begin
      w_eff = CW'(scr_w_r);
    end
    if (scr_h_r > MAX_H) begin
      h_eff = CW'(MAX_SCREEN_H);
    end else if (scr_h_r == '0) begin
      h_eff = CW'(1);
    end else begin
      h_eff = CW'(scr_h_r);
    end
  end

  assign cfg.src_w = src_w_r;
  assign cfg.src_h = src_h_r;
  assign cfg.pitch = pitch_r;

  nnsa_front #(
    .CW (CW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .in_restart (in_restart),
    .full       (full),
    .w_eff      (w_eff),
    .h_eff      (h_eff),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  nnsa_queue #(
    .DW (2*CW + 1)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .q_stat  (q_stat)
  );

  nnsa_back #(
    .CW (CW)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .w_eff            (w_eff),
    .h_eff            (h_eff),
    .cfg              (cfg),
    .empty            (empty),
    .pop              (pop),
    .out_source_index (out_source_index),
    .out_dest_index   (out_dest_index),
    .out_frame_last   (out_frame_last)
  );

endmodule

### sv/nnsa_checker.sv
// nnsa_checker: port-level assertions for the scale addresser, bound to the top
// depends on nnsa_pkg and nearest_neighbor_scale_addresser_top
module nnsa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        full,
  input logic                        empty,
  input logic                        pop,
  input logic [nnsa_pkg::IDX_W-1:0]  out_source_index,
  input logic [nnsa_pkg::IDX_W-1:0]  out_dest_index,
  input logic                        out_frame_last,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [nnsa_pkg::ADDR_W-1:0] paddr,
  input logic [nnsa_pkg::DATA_W-1:0] pwdata,
  input logic [nnsa_pkg::DATA_W-1:0] prdata,
  input logic                        pready
);

  // reset leaves no result and room for requests
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("result or full flag present after reset");

  // a waiting result stays put until popped
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_source_index) &&
                          $stable(out_dest_index) && $stable(out_frame_last)))
    else $error("waiting result changed before pop");

  // source width write reads back on the next cycle
  a_src_w_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready &&
     paddr[4:2] == nnsa_pkg::REG_SRC_W) |=>
    (paddr[4:2] != nnsa_pkg::REG_SRC_W ||
     prdata == nnsa_pkg::DATA_W'($past(pwdata[nnsa_pkg::SRC_DIM_W-1:0]))))
    else $error("source width readback mismatch");

  // pitch write reads back on the next cycle
  a_pitch_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready &&
     paddr[4:2] == nnsa_pkg::REG_PITCH) |=>
    (paddr[4:2] != nnsa_pkg::REG_PITCH ||
     prdata == nnsa_pkg::DATA_W'($past(pwdata[nnsa_pkg::PITCH_W-1:0]))))
    else $error("pitch readback mismatch");

endmodule

bind nearest_neighbor_scale_addresser_top nnsa_checker u_nnsa_checker (.*);

### bench/tb_nearest_neighbor_scale_addresser_top.sv
// tb_nearest_neighbor_scale_addresser_top: self-checking bench for the scale addresser
// depends on nnsa_pkg and nearest_neighbor_scale_addresser_top; predicts the raster
// walk, source and destination indexes and checks every popped result in order
module tb_nearest_neighbor_scale_addresser_top;

  localparam int MAX_W          = 1920;
  localparam int MAX_H          = 1200;
  localparam int CFG_AW         = nnsa_pkg::ADDR_W;
  localparam int FIRST_UNMAPPED = 5;
  localparam int LAST_UNMAPPED  = (1 << nnsa_pkg::ADDR_W) / 4 - 1;
  localparam int RANDOM_ITEMS   = 360;
  localparam int TALL_ITEMS     = 24;

  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_RANDOM,
    POP_SPARSE
  } pop_mode_t;

  typedef struct {
    logic [nnsa_pkg::IDX_W-1:0] src;
    logic [nnsa_pkg::IDX_W-1:0] dst;
    logic                       last;
  } pixel_addr_t;

  // raster walk predictor with its own copy of the registers
  class raster_scoreboard;
    logic [nnsa_pkg::SRC_DIM_W-1:0] src_w, src_h;
    logic [nnsa_pkg::SCR_DIM_W-1:0] scr_w, scr_h;
    logic [nnsa_pkg::PITCH_W-1:0]   pitch;
    int unsigned                    col, row, max_w, max_h;
    pixel_addr_t                    pixel_q[$];
    int                             errors, checked, frame_ends, requests;

    function new(int unsigned mw, int unsigned mh);
      max_w = mw;
      max_h = mh;
      src_w = nnsa_pkg::SRC_W_RST;
      src_h = nnsa_pkg::SRC_H_RST;
      scr_w = nnsa_pkg::SCR_W_RST;
      scr_h = nnsa_pkg::SCR_H_RST;
      pitch = nnsa_pkg::PITCH_RST;
      col = 0;
      row = 0;
    endfunction

    function void write_reg(int idx, logic [nnsa_pkg::DATA_W-1:0] data);
      case (idx)
        nnsa_pkg::REG_SRC_W: src_w = data[nnsa_pkg::SRC_DIM_W-1:0];
        nnsa_pkg::REG_SRC_H: src_h = data[nnsa_pkg::SRC_DIM_W-1:0];
        nnsa_pkg::REG_SCR_W: scr_w = data[nnsa_pkg::SCR_DIM_W-1:0];
        nnsa_pkg::REG_SCR_H: scr_h = data[nnsa_pkg::SCR_DIM_W-1:0];
        nnsa_pkg::REG_PITCH: pitch = data[nnsa_pkg::PITCH_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned maxv);
      if (v > maxv) v = maxv;
      if (v == 0) v = 1;
      return v;
    endfunction

    function void note_request(logic restart);
      int unsigned       w, h;
      longint unsigned   x, y, sx, sy, src, dst;
      pixel_addr_t       p;
      w = clamp_dim(scr_w, max_w);
      h = clamp_dim(scr_h, max_h);
      // restart, or a screen that shrank under the current position
      if (restart || col >= w || row >= h) begin
        col = 0;
        row = 0;
      end
      x = col;
      y = row;
      sx = (x * longint'(src_w)) / w;
      sy = (y * longint'(src_h)) / h;
      src = sy * longint'(src_w) + sx;
      dst = y * longint'(pitch) + x;
      p.src = src[nnsa_pkg::IDX_W-1:0];
      p.dst = dst[nnsa_pkg::IDX_W-1:0];
      p.last = (col == w - 1) && (row == h - 1);
      pixel_q.push_back(p);
      requests++;
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col++;
      end
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    task check_result(logic [nnsa_pkg::IDX_W-1:0] src, logic [nnsa_pkg::IDX_W-1:0] dst,
                      logic last);
      pixel_addr_t e;
      if (pixel_q.size() == 0) begin
        report($sformatf("result %0d popped with no request pending", checked));
        return;
      end
      e = pixel_q.pop_front();
      if (src !== e.src)
        report($sformatf("result %0d source_index %0h, expected %0h", checked, src, e.src));
      if (dst !== e.dst)
        report($sformatf("result %0d dest_index %0h, expected %0h", checked, dst, e.dst));
      if (last !== e.last)
        report($sformatf("result %0d frame_last %0b, expected %0b", checked, last, e.last));
      if (e.last) frame_ends++;
      checked++;
    endtask

    task close_out();
      if (pixel_q.size() != 0)
        report($sformatf("%0d results never arrived", pixel_q.size()));
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          push = 1'b0;
  logic                          in_restart = 1'b0;
  logic                          pop = 1'b0;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [CFG_AW-1:0]             paddr = '0;
  logic [nnsa_pkg::DATA_W-1:0]   pwdata = '0;
  logic                          full, empty, out_frame_last, pready;
  logic [nnsa_pkg::IDX_W-1:0]    out_source_index, out_dest_index;
  logic [nnsa_pkg::DATA_W-1:0]   prdata;

  raster_scoreboard    sb;
  pop_mode_t           pop_mode = POP_ALWAYS;
  logic [6:0]          pop_tick = '0;
  int                  random_items = 0;

  nearest_neighbor_scale_addresser_top #(
    .MAX_SCREEN_W(MAX_W),
    .MAX_SCREEN_H(MAX_H)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_restart(in_restart),
    .empty(empty),
    .pop(pop),
    .out_source_index(out_source_index),
    .out_dest_index(out_dest_index),
    .out_frame_last(out_frame_last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("timeout with %0d results still pending", sb.pending());
    $display("nearest_neighbor_scale_addresser_top regression: fail");
    $finish;
  end

  // result side: check on each pop, stall in modes that change when the 7-bit pop tick wraps
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) sb.check_result(out_source_index, out_dest_index, out_frame_last);
      pop_tick <= pop_tick + 1'b1;
      if (pop_tick == 0) pop_mode <= pop_mode_t'($urandom_range(0, 2));
      case (pop_mode)
        POP_ALWAYS: pop <= 1'b1;
        POP_RANDOM: pop <= 1'($urandom_range(0, 1));
        default: pop <= (pop_tick[3:0] < 3);
      endcase
    end
  end

  task automatic cfg_write(input int idx, input logic [nnsa_pkg::DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(idx * 4);
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(idx, data);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // sends one request per entry, in bursts with gaps unless gaps is clear
  task automatic send_run(input logic restart_bits[$], input bit gaps);
    int burst_left, gap;
    burst_left = $urandom_range(1, 16);
    for (int i = 0; i < restart_bits.size(); i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = gaps ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      push <= 1'b1;
      in_restart <= restart_bits[i];
      @(posedge clk);
      while (full) @(posedge clk);
      sb.note_request(restart_bits[i]);
      burst_left--;
    end
    push <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [nnsa_pkg::DATA_W-1:0] pick_reg_value(int idx);
    logic [nnsa_pkg::DATA_W-1:0] mask;
    int unsigned                 small_max;
    case (idx)
      nnsa_pkg::REG_SRC_W, nnsa_pkg::REG_SRC_H: begin
        mask = 32'h1FFF;
        small_max = 64;
      end
      nnsa_pkg::REG_SCR_W, nnsa_pkg::REG_SCR_H: begin
        mask = 32'hFFF;
        small_max = 6;
      end
      default: begin
        mask = 32'h3FFF;
        small_max = 100;
      end
    endcase
    case ($urandom_range(0, 9))
      0: return '0;
      1: return mask;
      2: return $urandom;
      3: return 1;
      default: return $urandom_range(1, small_max);
    endcase
  endfunction

  initial begin
    logic restart_bits[$];
    int   n, restart_pct;
    sb = new(MAX_W, MAX_H);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, restart mid-line
    restart_bits = '{0, 0, 1, 0};
    send_run(restart_bits, 1'b1);
    wait_idle();

    // zero source and pitch, clamped screen, unmapped writes change nothing
    cfg_write(nnsa_pkg::REG_SRC_W, 32'h0);
    cfg_write(nnsa_pkg::REG_SRC_H, 32'h0);
    cfg_write(nnsa_pkg::REG_SCR_W, 32'hFFF);
    cfg_write(nnsa_pkg::REG_SCR_H, 32'hFFF);
    cfg_write(nnsa_pkg::REG_PITCH, 32'h0);
    for (int i = FIRST_UNMAPPED; i <= LAST_UNMAPPED; i++) cfg_write(i, 32'hFFFF_FFFF);
    restart_bits = '{0, 0, 0};
    send_run(restart_bits, 1'b1);
    wait_idle();

    // screen shrunk under the position, full frame with index wrap and frame end
    cfg_write(nnsa_pkg::REG_SRC_W, 32'hFFFF_FFFF);
    cfg_write(nnsa_pkg::REG_SRC_H, 32'h1FFF);
    cfg_write(nnsa_pkg::REG_SCR_W, 32'd2);
    cfg_write(nnsa_pkg::REG_SCR_H, 32'd4);
    cfg_write(nnsa_pkg::REG_PITCH, 32'h3FFF);
    restart_bits = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_run(restart_bits, 1'b0);
    wait_idle();

    // zero screen size acts as a one pixel frame
    cfg_write(nnsa_pkg::REG_SCR_W, 32'h0);
    cfg_write(nnsa_pkg::REG_SCR_H, 32'hFFFF_F000);
    restart_bits = '{0, 1, 0};
    send_run(restart_bits, 1'b1);
    wait_idle();

    // random settings between runs; the position carries over from run to run
    while (random_items < RANDOM_ITEMS) begin
      for (int r = nnsa_pkg::REG_SRC_W; r <= nnsa_pkg::REG_PITCH; r++)
        if ($urandom_range(0, 9) < 6) cfg_write(r, pick_reg_value(r));
      if ($urandom_range(0, 5) == 0)
        cfg_write($urandom_range(FIRST_UNMAPPED, LAST_UNMAPPED), $urandom);
      case ($urandom_range(0, 2))
        0: restart_pct = 0;
        1: restart_pct = 6;
        default: restart_pct = 50;
      endcase
      n = $urandom_range(8, 40);
      restart_bits = {};
      for (int i = 0; i < n; i++) restart_bits.push_back($urandom_range(0, 99) < restart_pct);
      send_run(restart_bits, $urandom_range(0, 3) != 0);
      random_items += n;
      wait_idle();
    end

    // one-column screen of clamped height walks the first rows
    cfg_write(nnsa_pkg::REG_SRC_W, $urandom_range(4096, 8191));
    cfg_write(nnsa_pkg::REG_SRC_H, $urandom);
    cfg_write(nnsa_pkg::REG_SCR_W, $urandom_range(0, 1));
    cfg_write(nnsa_pkg::REG_SCR_H, $urandom_range(MAX_H, 4095));
    cfg_write(nnsa_pkg::REG_PITCH, 32'h3FFF);
    restart_bits = {};
    restart_bits.push_back(1'b1);
    for (int i = 1; i < TALL_ITEMS; i++) restart_bits.push_back(1'b0);
    send_run(restart_bits, 1'b1);

    wait_idle();
    repeat (60) @(posedge clk);
    sb.close_out();
    $display("checked %0d results from %0d requests, %0d frame ends seen",
             sb.checked, sb.requests, sb.frame_ends);
    $display("covered reset values, clamped and zero screens, shrink mid-frame, index wrap");
    if (sb.errors == 0) begin
      $display("nearest_neighbor_scale_addresser_top regression: pass");
    end else begin
      $display("nearest_neighbor_scale_addresser_top regression: fail");
    end
    $finish;
  end

endmodule

### nearest_neighbor_scale_addresser_top.f
sv/nnsa_pkg.sv
sv/nnsa_front.sv
sv/nnsa_queue.sv
sv/nnsa_back.sv
sv/nearest_neighbor_scale_addresser_top.sv
sv/nnsa_checker.sv
bench/tb_nearest_neighbor_scale_addresser_top.sv
